@@ rtl/scaled_glyph_row_expander_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the scaled glyph row expander
// Concurrent assertion wrappers that can be compiled out as a group.
// ----------------------------------------------------------------------------
`ifndef SCALED_GLYPH_ROW_EXPANDER_MACROS_SVH
`define SCALED_GLYPH_ROW_EXPANDER_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define SGRE_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define SGRE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define SGRE_ASSERT_SAME(label, clk, rst, ante, cons)
`define SGRE_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ rtl/sgre_pkg.sv @@
// ----------------------------------------------------------------------------
// Scaled glyph row expander package
// Shared widths, codes, types and the color byte swap.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sgre_pkg;

   localparam int SROW_W      = 7;
   localparam int SCALE_W     = 4;
   localparam int COLOR_W     = 32;
   localparam int ADDR_FULL_W = 12;
   localparam int CSR_INDEX_W = 2;

   localparam logic OP_LOAD   = 1'b0;
   localparam logic OP_RENDER = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_SCALE_FACTOR    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BACKGROUND_RGBA = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FOREGROUND_RGBA = 2'd2;

   localparam logic [SCALE_W-1:0] SCALE_MIN = 4'd1;
   localparam logic [SCALE_W-1:0] SCALE_MAX = 4'd8;

   typedef struct packed {
      logic              done;
      logic [SROW_W-1:0] quotient;
   } sgre_div_result_type;

   function automatic logic [COLOR_W-1:0] swap_bytes(input logic [COLOR_W-1:0] value);
      swap_bytes = {value[7:0], value[15:8], value[23:16], value[31:24]};
   endfunction

endpackage

`default_nettype wire

@@ rtl/sgre_row_divider.sv @@
// ----------------------------------------------------------------------------
// Row divider
// Finds the unscaled font row by repeated subtraction, one step per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sgre_row_divider
   import sgre_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [SROW_W-1:0]   dividend,
   input  wire logic [SCALE_W-1:0]  divisor,
   output sgre_div_result_type      result
);

   logic                busy_ff, busy_in;
   logic [SROW_W-1:0]   rem_ff, rem_in;
   logic [SROW_W-1:0]   quo_ff, quo_in;
   logic [SCALE_W-1:0]  div_ff, div_in;
   logic                fits;

   assign fits = rem_ff >= SROW_W'(div_ff);

   always_comb begin
      busy_in = busy_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      div_in  = div_ff;
      if (start) begin
         busy_in = 1'b1;
         rem_in  = dividend;
         quo_in  = '0;
         div_in  = divisor;
      end else if (busy_ff) begin
         if (fits) begin
            rem_in = rem_ff - SROW_W'(div_ff);
            quo_in = quo_ff + SROW_W'(1);
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      div_ff <= div_in;
   end

   assign result.done     = busy_ff && !fits;
   assign result.quotient = quo_ff;

endmodule

`default_nettype wire

@@ rtl/scaled_glyph_row_expander.sv @@
// Render: the accepted transfer starts the row divider, which finds r = scaled_row / scale
// by repeated subtraction; then one glyph store read fetches the unscaled font row.
// Pixels then follow one per cycle while rsp_stall does not hold them, GLYPH_WIDTH * scale
// of them; the next request is taken once the last pixel is loaded, and a load leaves the block idle.
// A row out of range gives its single result through S_OOR and the output register.
// Reset restores the register defaults; the glyph store is not cleared.
// ----------------------------------------------------------------------------
// Scaled glyph row expander
// Bitmap character generator with a font store and integer pixel replication.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "scaled_glyph_row_expander_macros.svh"

module scaled_glyph_row_expander
   import sgre_pkg::*;
#(
   parameter int GLYPH_WIDTH  = 8,
   parameter int GLYPH_HEIGHT = 16,
   parameter int GLYPH_COUNT  = 256
) (
   input  wire logic                    clock,
   input  wire logic                    reset,

   input  wire logic                    csr_write_enable,
   input  wire logic [CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [COLOR_W-1:0]      csr_write_data,

   input  wire logic                    req_valid,
   output      logic                    req_stall,
   input  wire logic                    req_op,
   input  wire logic [7:0]              req_glyph_code,
   input  wire logic [3:0]              req_font_row,
   input  wire logic [7:0]              req_row_bits,
   input  wire logic [SROW_W-1:0]       req_scaled_row,

   output      logic                    rsp_valid,
   input  wire logic                    rsp_stall,
   output      logic [COLOR_W-1:0]      rsp_pixel_word,
   output      logic [5:0]              rsp_pixel_column,
   output      logic                    rsp_last_pixel,
   output      logic                    rsp_row_out_of_range
);

   localparam int DEPTH = GLYPH_COUNT * GLYPH_HEIGHT;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int RW    = (GLYPH_HEIGHT > 1) ? $clog2(GLYPH_HEIGHT) : 1;

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DIV  = 2'd1;
   localparam logic [1:0] S_EMIT = 2'd2;
   localparam logic [1:0] S_OOR  = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [SCALE_W-1:0]  scale_cfg_ff, scale_cfg_in;
   logic [COLOR_W-1:0]  bg_ff, bg_in;
   logic [COLOR_W-1:0]  fg_ff, fg_in;

   logic [7:0]          code_ff, code_in;
   logic                code_ok_ff, code_ok_in;
   logic [SCALE_W-1:0]  scale_ff, scale_in;
   logic [6:0]          n_ff, n_in;
   logic [5:0]          col_ff, col_in;
   logic [2:0]          x_ff, x_in;
   logic [2:0]          sub_ff, sub_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [COLOR_W-1:0]  word_ff, word_in;
   logic [5:0]          column_ff, column_in;
   logic                last_ff, last_in;
   logic                oor_ff, oor_in;

   logic [7:0]          glyph_store_mem [DEPTH];
   logic [7:0]          rd_data_ff;

   logic                accept;
   logic                out_free;
   logic                out_load;
   logic [SCALE_W-1:0]  scale_eff;
   logic [7:0]          row_limit;
   logic                row_oor;
   logic                code_in_range;
   logic                wr_en;
   logic [ADDR_FULL_W-1:0] wr_addr_full;
   logic                rd_en;
   logic [ADDR_FULL_W-1:0] rd_addr_full;
   logic                div_start;
   sgre_div_result_type div_res;
   logic [7:0]          glyph_byte;
   logic                dot;
   logic                is_last;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (scale_cfg_ff == '0) begin
         scale_eff = SCALE_MIN;
      end else if (scale_cfg_ff > SCALE_MAX) begin
         scale_eff = SCALE_MAX;
      end else begin
         scale_eff = scale_cfg_ff;
      end
   end

   assign row_limit     = 8'(GLYPH_HEIGHT) * 8'(scale_eff);
   assign row_oor       = 8'(req_scaled_row) >= row_limit;
   assign code_in_range = 9'(req_glyph_code) < 9'(GLYPH_COUNT);

   assign wr_en = accept && (req_op == OP_LOAD) && code_in_range
                  && (5'(req_font_row) < 5'(GLYPH_HEIGHT));
   assign wr_addr_full = ADDR_FULL_W'(req_glyph_code) * ADDR_FULL_W'(GLYPH_HEIGHT)
                         + ADDR_FULL_W'(req_font_row);

   assign div_start = accept && (req_op == OP_RENDER) && !row_oor;

   sgre_row_divider u_row_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (req_scaled_row),
      .divisor  (scale_eff),
      .result   (div_res)
   );

   assign rd_en = (state_ff == S_DIV) && div_res.done && code_ok_ff;
   assign rd_addr_full = ADDR_FULL_W'(code_ff) * ADDR_FULL_W'(GLYPH_HEIGHT)
                         + ADDR_FULL_W'(div_res.quotient[RW-1:0]);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         glyph_store_mem[AW'(wr_addr_full)] <= req_row_bits;
      end
      if (rd_en) begin
         rd_data_ff <= glyph_store_mem[AW'(rd_addr_full)];
      end
   end

   assign glyph_byte = code_ok_ff ? rd_data_ff : 8'd0;
   assign dot        = glyph_byte[3'd7 - x_ff];
   assign is_last    = (7'(col_ff) + 7'd1) == n_ff;

   always_comb begin
      scale_cfg_in = scale_cfg_ff;
      bg_in        = bg_ff;
      fg_in        = fg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SCALE_FACTOR:    scale_cfg_in = csr_write_data[SCALE_W-1:0];
            CSR_BACKGROUND_RGBA: bg_in        = csr_write_data;
            CSR_FOREGROUND_RGBA: fg_in        = csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in   = state_ff;
      code_in    = code_ff;
      code_ok_in = code_ok_ff;
      scale_in   = scale_ff;
      n_in       = n_ff;
      col_in     = col_ff;
      x_in       = x_ff;
      sub_in     = sub_ff;
      out_load   = 1'b0;
      word_in    = word_ff;
      column_in  = column_ff;
      last_in    = last_ff;
      oor_in     = oor_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept && (req_op == OP_RENDER)) begin
               code_in    = req_glyph_code;
               code_ok_in = code_in_range;
               scale_in   = scale_eff;
               n_in       = 7'(GLYPH_WIDTH) * 7'(scale_eff);
               state_in   = row_oor ? S_OOR : S_DIV;
            end
         end
         S_DIV: begin
            if (div_res.done) begin
               col_in   = '0;
               x_in     = '0;
               sub_in   = '0;
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (out_free) begin
               out_load  = 1'b1;
               word_in   = swap_bytes(dot ? fg_ff : bg_ff);
               column_in = col_ff;
               last_in   = is_last;
               oor_in    = 1'b0;
               if (is_last) begin
                  state_in = S_IDLE;
               end else begin
                  col_in = col_ff + 6'd1;
                  if ((4'(sub_ff) + 4'd1) == scale_ff) begin
                     sub_in = '0;
                     x_in   = x_ff + 3'd1;
                  end else begin
                     sub_in = sub_ff + 3'd1;
                  end
               end
            end
         end
         S_OOR: begin
            if (out_free) begin
               out_load  = 1'b1;
               word_in   = '0;
               column_in = '0;
               last_in   = 1'b1;
               oor_in    = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         scale_cfg_ff <= SCALE_MIN;
         bg_ff        <= 32'h0000_00FF;
         fg_ff        <= 32'hFFFF_FFFF;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         scale_cfg_ff <= scale_cfg_in;
         bg_ff        <= bg_in;
         fg_ff        <= fg_in;
      end
      code_ff    <= code_in;
      code_ok_ff <= code_ok_in;
      scale_ff   <= scale_in;
      n_ff       <= n_in;
      col_ff     <= col_in;
      x_ff       <= x_in;
      sub_ff     <= sub_in;
      word_ff    <= word_in;
      column_ff  <= column_in;
      last_ff    <= last_in;
      oor_ff     <= oor_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_pixel_word       = word_ff;
   assign rsp_pixel_column     = column_ff;
   assign rsp_last_pixel       = last_ff;
   assign rsp_row_out_of_range = oor_ff;

   `SGRE_ASSERT_SAME(a_div_done_in_div, clock, reset, div_res.done, state_ff == S_DIV)
   `SGRE_ASSERT_SAME(a_col_in_row, clock, reset, state_ff == S_EMIT, 7'(col_ff) < n_ff)
   `SGRE_ASSERT_SAME(a_oor_single, clock, reset, rsp_valid_ff && oor_ff,
                     last_ff && (column_ff == 6'd0) && (word_ff == '0))
   `SGRE_ASSERT_NEXT(a_load_no_result, clock, reset,
                     accept && (req_op == OP_LOAD), state_ff == S_IDLE)

endmodule

`default_nettype wire

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scaled glyph row expander testbench
// Loads font rows and renders scaled glyph rows under several register
// settings, with random request gaps and response stalls. A scoreboard keeps
// its own font store and predicts every pixel, and each pixel is checked in
// order.
// ----------------------------------------------------------------------------

import sgre_pkg::*;

localparam int GLYPH_WIDTH  = 8;
localparam int GLYPH_HEIGHT = 16;
localparam int GLYPH_COUNT  = 256;
localparam int MAX_PRINTED  = 60;

typedef struct packed {
   logic [COLOR_W-1:0] color_word;
   logic [5:0]         column;
   logic               last;
   logic               out_of_range;
} expected_pixel_type;

class glyph_row_scoreboard_type;
   logic [7:0]         font_rows [0:GLYPH_COUNT*GLYPH_HEIGHT-1];
   logic [SCALE_W-1:0] scale_reg;
   logic [COLOR_W-1:0] background;
   logic [COLOR_W-1:0] foreground;
   expected_pixel_type expected_pixels [$];
   int                 mismatches;
   int                 pixels_checked;
   int                 loads;
   int                 renders;
   int                 rows_out_of_range;

   function new();
      scale_reg  = 4'd1;
      background = 32'h0000_00FF;
      foreground = 32'hFFFF_FFFF;
   endfunction

   function int effective_scale();
      if (scale_reg == 4'd0) begin
         return 1;
      end
      if (scale_reg > SCALE_MAX) begin
         return 8;
      end
      return int'(scale_reg);
   endfunction

   function logic [COLOR_W-1:0] memory_order(input logic [COLOR_W-1:0] rgba);
      return {rgba[7:0], rgba[15:8], rgba[23:16], rgba[31:24]};
   endfunction

   function void write_register(input logic [CSR_INDEX_W-1:0] index,
                                input logic [COLOR_W-1:0] data);
      case (index)
         CSR_SCALE_FACTOR: begin
            scale_reg = data[SCALE_W-1:0];
         end
         CSR_BACKGROUND_RGBA: begin
            background = data;
         end
         CSR_FOREGROUND_RGBA: begin
            foreground = data;
         end
         default: begin
         end
      endcase
   endfunction

   function void note_input(input logic op, input logic [7:0] code,
                            input logic [3:0] frow, input logic [7:0] row_byte,
                            input logic [SROW_W-1:0] srow);
      int                 s;
      int                 n;
      int                 unscaled_row;
      logic [7:0]         font_byte;
      logic               dot;
      expected_pixel_type px;
      if (op == OP_LOAD) begin
         font_rows[{code, frow}] = row_byte;
         loads++;
      end else begin
         renders++;
         s = effective_scale();
         if (int'(srow) >= GLYPH_HEIGHT * s) begin
            px.color_word   = '0;
            px.column       = '0;
            px.last         = 1'b1;
            px.out_of_range = 1'b1;
            expected_pixels.push_back(px);
            rows_out_of_range++;
         end else begin
            unscaled_row = int'(srow) / s;
            font_byte = font_rows[{code, 4'(unscaled_row)}];
            n = GLYPH_WIDTH * s;
            for (int col = 0; col < n; col++) begin
               dot = font_byte[7 - col / s];
               px.color_word   = memory_order(dot ? foreground : background);
               px.column       = 6'(col);
               px.last         = (col == n - 1);
               px.out_of_range = 1'b0;
               expected_pixels.push_back(px);
            end
         end
      end
   endfunction

   task report(input string what);
      mismatches++;
      if (mismatches <= MAX_PRINTED) begin
         $display("%0t mismatch: %s", $realtime, what);
      end
   endtask

   task check_result(input logic [COLOR_W-1:0] color_word, input logic [5:0] column,
                     input logic last, input logic out_of_range);
      expected_pixel_type want;
      if (expected_pixels.size() == 0) begin
         report($sformatf("unexpected pixel %h at column %0d", color_word, column));
      end else begin
         want = expected_pixels.pop_front();
         pixels_checked++;
         if (color_word !== want.color_word) begin
            report($sformatf("pixel word %h, expected %h", color_word, want.color_word));
         end
         if (column !== want.column) begin
            report($sformatf("pixel column %0d, expected %0d", column, want.column));
         end
         if (last !== want.last) begin
            report($sformatf("last pixel flag %b, expected %b", last, want.last));
         end
         if (out_of_range !== want.out_of_range) begin
            report($sformatf("row out of range flag %b, expected %b", out_of_range,
                             want.out_of_range));
         end
      end
   endtask
endclass

module testbench;

   localparam int CYCLE_LIMIT      = 1_000_000;
   localparam int SETTLE_CYCLES    = 20;
   localparam int END_CYCLES       = 100;
   localparam int LONG_HOLD_CYCLES = 400;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_SCALE_FACTOR;
   logic [COLOR_W-1:0]     csr_write_data = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_op = OP_LOAD;
   logic [7:0]             req_glyph_code = '0;
   logic [3:0]             req_font_row = '0;
   logic [7:0]             req_row_bits = '0;
   logic [SROW_W-1:0]      req_scaled_row = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b1;
   logic [COLOR_W-1:0]     rsp_pixel_word;
   logic [5:0]             rsp_pixel_column;
   logic                   rsp_last_pixel;
   logic                   rsp_row_out_of_range;

   glyph_row_scoreboard_type sb = new();
   bit                  entry_loaded [0:GLYPH_COUNT*GLYPH_HEIGHT-1];
   int                  loaded_entries [$];
   bit                  sender_idle = 1'b1;
   bit                  receiver_idle = 1'b1;
   bit                  long_hold_request = 1'b0;
   int                  long_holds = 0;
   int                  settings_used = 1;
   int                  cycle_count = 0;

   scaled_glyph_row_expander #(
      .GLYPH_WIDTH(GLYPH_WIDTH),
      .GLYPH_HEIGHT(GLYPH_HEIGHT),
      .GLYPH_COUNT(GLYPH_COUNT)
   ) dut (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_op(req_op),
      .req_glyph_code(req_glyph_code),
      .req_font_row(req_font_row),
      .req_row_bits(req_row_bits),
      .req_scaled_row(req_scaled_row),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_pixel_word(rsp_pixel_word),
      .rsp_pixel_column(rsp_pixel_column),
      .rsp_last_pixel(rsp_last_pixel),
      .rsp_row_out_of_range(rsp_row_out_of_range)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[scaled_glyph_row_expander] ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_result(rsp_pixel_word, rsp_pixel_column, rsp_last_pixel,
                         rsp_row_out_of_range);
      end
   end

   initial begin : receiver
      bit hold;
      int span;
      forever begin
         if (long_hold_request) begin
            hold = 1'b1;
            span = LONG_HOLD_CYCLES;
            long_hold_request = 1'b0;
            long_holds++;
         end else if (receiver_idle && $urandom_range(0, 1) == 0) begin
            hold = 1'b1;
            span = $urandom_range(1, 15);
         end else begin
            hold = 1'b0;
            span = $urandom_range(1, 20);
         end
         rsp_stall <= hold;
         repeat (span) @(posedge clock);
      end
   end

   task automatic send_item(input logic op, input logic [7:0] code, input logic [3:0] frow,
                            input logic [7:0] row_byte, input logic [SROW_W-1:0] srow);
      if (sender_idle && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_op         <= op;
      req_glyph_code <= code;
      req_font_row   <= frow;
      req_row_bits   <= row_byte;
      req_scaled_row <= srow;
      do begin
         @(posedge clock);
      end while (req_stall);
      sb.note_input(op, code, frow, row_byte, srow);
   endtask

   task automatic load_row(input logic [7:0] code, input logic [3:0] frow,
                           input logic [7:0] row_byte);
      if (!entry_loaded[{code, frow}]) begin
         entry_loaded[{code, frow}] = 1'b1;
         loaded_entries.push_back(int'({code, frow}));
      end
      send_item(OP_LOAD, code, frow, row_byte, SROW_W'($urandom));
   endtask

   task automatic render_row(input logic [7:0] code, input int srow);
      send_item(OP_RENDER, code, 4'($urandom), 8'($urandom), SROW_W'(srow));
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] index,
                            input logic [COLOR_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      @(posedge clock);
      sb.write_register(index, data);
   endtask

   task automatic set_registers(input logic [SCALE_W-1:0] scale,
                                input logic [COLOR_W-1:0] bg, input logic [COLOR_W-1:0] fg);
      csr_write(CSR_SCALE_FACTOR, {28'($urandom), scale});
      csr_write(CSR_BACKGROUND_RGBA, bg);
      csr_write(CSR_FOREGROUND_RGBA, fg);
      csr_write_enable <= 1'b0;
      settings_used++;
   endtask

   task automatic drain(input int settle);
      req_valid <= 1'b0;
      while (sb.expected_pixels.size() != 0) begin
         @(posedge clock);
      end
      repeat (settle) @(posedge clock);
   endtask

   task automatic random_traffic(input int count);
      int         sent;
      int         kind;
      int         s;
      int         pick;
      logic [7:0] code;
      logic [3:0] frow;
      sent = 0;
      while (sent < count) begin
         s = sb.effective_scale();
         kind = $urandom_range(0, 9);
         if (kind < 4 || loaded_entries.size() == 0) begin
            code = 8'($urandom);
            frow = 4'($urandom);
            load_row(code, frow, 8'($urandom));
            render_row(code, int'(frow) * s + $urandom_range(0, s - 1));
            sent += 2;
         end else if (kind < 7 || (kind == 7 && s == 8)) begin
            pick = loaded_entries[$urandom_range(0, loaded_entries.size() - 1)];
            render_row(pick[11:4], int'(pick[3:0]) * s + $urandom_range(0, s - 1));
            sent++;
         end else if (kind == 7) begin
            render_row(8'($urandom), $urandom_range(GLYPH_HEIGHT * s, 127));
            sent++;
         end else begin
            load_row(8'($urandom), 4'($urandom), 8'($urandom));
            sent++;
         end
      end
   endtask

   initial begin : stimulus
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      load_row(8'h00, 4'd0, 8'h00);
      load_row(8'hFF, 4'd15, 8'hFF);
      load_row(8'hA5, 4'd5, 8'h81);
      load_row(8'h5A, 4'd10, 8'h7E);
      load_row(8'h01, 4'd1, 8'h80);
      load_row(8'h02, 4'd2, 8'h01);
      render_row(8'h00, 0);
      render_row(8'hFF, 15);
      render_row(8'hA5, 5);
      render_row(8'h5A, 10);
      render_row(8'h01, 1);
      render_row(8'h02, 2);
      render_row(8'h00, 16);
      render_row(8'hFF, 127);
      load_row(8'h33, 4'd7, 8'h5A);
      render_row(8'h33, 7);
      load_row(8'h33, 4'd7, 8'hC3);
      render_row(8'h33, 7);
      drain(SETTLE_CYCLES);

      set_registers(SCALE_MAX, 32'h0000_0000, 32'hFFFF_FFFF);
      render_row(8'hFF, 127);
      render_row(8'hA5, 40);
      render_row(8'h33, 63);
      drain(SETTLE_CYCLES);

      // A scale of zero behaves as one, anything above eight as eight.
      set_registers(4'd0, 32'h1234_5678, 32'h9ABC_DEF0);
      render_row(8'h00, 16);
      render_row(8'h02, 2);
      drain(SETTLE_CYCLES);
      set_registers(4'd15, 32'hFFFF_FFFF, 32'h0000_0000);
      render_row(8'hFF, 127);
      render_row(8'h01, 9);
      drain(SETTLE_CYCLES);

      set_registers(4'd2, $urandom, $urandom);
      random_traffic(20);
      drain(SETTLE_CYCLES);

      set_registers(4'd1, 32'hFFFF_FFFF, 32'h0000_0000);
      random_traffic(20);
      drain(SETTLE_CYCLES);

      // The receiver holds off for a long stretch so the block backs up.
      set_registers(4'($urandom_range(3, 7)), $urandom, $urandom);
      long_hold_request = 1'b1;
      random_traffic(20);
      drain(SETTLE_CYCLES);

      sender_idle   = 1'b0;
      receiver_idle = 1'b0;
      set_registers(4'($urandom_range(1, 8)), $urandom, $urandom);
      random_traffic(20);
      drain(END_CYCLES);

      if (sb.expected_pixels.size() != 0) begin
         sb.report($sformatf("%0d pixels never arrived", sb.expected_pixels.size()));
      end
      $display("Run covered %0d font row loads and %0d row renders (%0d out of range)",
               sb.loads, sb.renders, sb.rows_out_of_range);
      $display("over %0d register settings and %0d long receiver holds; %0d pixels checked.",
               settings_used, long_holds, sb.pixels_checked);
      if (sb.mismatches == 0) begin
         $display("[scaled_glyph_row_expander] OK");
      end else begin
         $display("[scaled_glyph_row_expander] ERROR");
      end
      $finish;
   end

endmodule
